### rtl/mlfd_pkg.sv
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  localparam int BYTE_W   = 8;
  localparam int MAXLEN_W = 31;
  localparam int LEN_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0]   MAGIC_FIRST_RST  = 8'd117;  // 'u'
  localparam logic [BYTE_W-1:0]   MAGIC_SECOND_RST = 8'd118;  // 'v'
  localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST   = 31'd65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_FIRST  = 2'd0,
    CFG_MAGIC_SECOND = 2'd1,
    CFG_MAX_LENGTH   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_MAGIC1  = 3'd0,
    PH_MAGIC2  = 3'd1,
    PH_LEN0    = 3'd2,
    PH_LEN1    = 3'd3,
    PH_LEN2    = 3'd4,
    PH_LEN3    = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_HUNT    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_BAD_MAGIC = 2'd2,
    KIND_BAD_LEN   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   magic_first;
    logic [BYTE_W-1:0]   magic_second;
    logic [MAXLEN_W-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } result_t;

endpackage

### rtl/magic_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// magic_length_frame_deframer
// Splits a byte stream into magic/length-prefixed frames and reports errors.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  in      | in_valid / in_stall  | in_byte
//  out     | out_valid / out_stall| kind, out_byte, last
//  cfg     | cfg_wen              | cfg_index, cfg_data
//
// One byte per cycle sustained while in_stall is low: input register, parser
// logic, result register. Hunted bytes give no result and are consumed;
// header bytes give a result only on bad magic, bad length or empty frame.
// in_stall rises only while the result register is full and out_stall holds.
// rst is synchronous and returns the parser to waiting for the first magic
// byte with the configuration at its defaults.
// ----------------------------------------------------------------------------
module magic_length_frame_deframer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mlfd_pkg::BYTE_W-1:0]       in_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        kind,
  output logic [mlfd_pkg::BYTE_W-1:0]       out_byte,
  output logic                              last,
  input  logic                              cfg_wen,
  input  logic [mlfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlfd_pkg::MAXLEN_W-1:0]     cfg_data
);

  mlfd_pkg::cfg_t                    cfg;
  logic                              in_q_valid;
  logic [mlfd_pkg::BYTE_W-1:0]       in_q_byte;
  logic                              advance;
  logic                              step;
  mlfd_pkg::result_t                 res;

  // stage can move on when the result register is empty or draining
  assign advance  = !out_valid || !out_stall;
  assign step     = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first  <= mlfd_pkg::MAGIC_FIRST_RST;
      cfg.magic_second <= mlfd_pkg::MAGIC_SECOND_RST;
      cfg.max_length   <= mlfd_pkg::MAX_LENGTH_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        mlfd_pkg::CFG_MAGIC_FIRST:  cfg.magic_first  <= cfg_data[mlfd_pkg::BYTE_W-1:0];
        mlfd_pkg::CFG_MAGIC_SECOND: cfg.magic_second <= cfg_data[mlfd_pkg::BYTE_W-1:0];
        mlfd_pkg::CFG_MAX_LENGTH:   cfg.max_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte <= in_byte;
    end
  end

  mlfd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_q_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      kind     <= res.kind;
      out_byte <= res.data;
      last     <= res.last;
    end
  end

endmodule

### rtl/mlfd_core.sv
// ----------------------------------------------------------------------------
// mlfd_core
// Frame parser state and per-byte update; one byte handled per step.
// ----------------------------------------------------------------------------
module mlfd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [mlfd_pkg::BYTE_W-1:0]   in_byte,
  input  mlfd_pkg::cfg_t                cfg,
  output mlfd_pkg::result_t             res
);

  mlfd_pkg::phase_t                    phase, phase_next;
  // only the low three length bytes must be kept; the fourth arrives live
  logic [mlfd_pkg::LEN_W-9:0]          length_accum, length_accum_next;
  logic [mlfd_pkg::MAXLEN_W-1:0]       bytes_left, bytes_left_next;

  logic [mlfd_pkg::LEN_W-1:0]          full_len;
  logic [mlfd_pkg::MAXLEN_W-1:0]       left_dec;

  assign full_len = {length_accum, in_byte};
  assign left_dec = bytes_left - 1'b1;

  always_comb begin
    phase_next        = phase;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    res.valid = 1'b0;
    res.kind  = mlfd_pkg::KIND_DATA;
    res.data  = '0;
    res.last  = 1'b0;
    case (phase)
      mlfd_pkg::PH_MAGIC1: begin
        if (in_byte == cfg.magic_first) begin
          phase_next = mlfd_pkg::PH_MAGIC2;
        end else begin
          phase_next = mlfd_pkg::PH_HUNT;
          res.valid  = 1'b1;
          res.kind   = mlfd_pkg::KIND_BAD_MAGIC;
        end
      end
      mlfd_pkg::PH_HUNT: begin
        if (in_byte == cfg.magic_first) phase_next = mlfd_pkg::PH_MAGIC2;
      end
      mlfd_pkg::PH_MAGIC2: begin
        if (in_byte == cfg.magic_second) begin
          length_accum_next = '0;
          phase_next        = mlfd_pkg::PH_LEN0;
        end else begin
          phase_next = mlfd_pkg::PH_HUNT;
          res.valid  = 1'b1;
          res.kind   = mlfd_pkg::KIND_BAD_MAGIC;
        end
      end
      mlfd_pkg::PH_LEN0, mlfd_pkg::PH_LEN1, mlfd_pkg::PH_LEN2: begin
        length_accum_next = full_len[mlfd_pkg::LEN_W-9:0];
        phase_next        = mlfd_pkg::phase_t'(phase + 3'd1);
      end
      mlfd_pkg::PH_LEN3: begin
        length_accum_next = full_len[mlfd_pkg::LEN_W-9:0];
        // sign bit set or above the limit
        if (full_len[mlfd_pkg::LEN_W-1] ||
            (full_len[mlfd_pkg::MAXLEN_W-1:0] > cfg.max_length)) begin
          phase_next = mlfd_pkg::PH_HUNT;
          res.valid  = 1'b1;
          res.kind   = mlfd_pkg::KIND_BAD_LEN;
        end else if (full_len == '0) begin
          phase_next = mlfd_pkg::PH_MAGIC1;
          res.valid  = 1'b1;
          res.kind   = mlfd_pkg::KIND_EMPTY;
          res.last   = 1'b1;
        end else begin
          bytes_left_next = full_len[mlfd_pkg::MAXLEN_W-1:0];
          phase_next      = mlfd_pkg::PH_PAYLOAD;
        end
      end
      mlfd_pkg::PH_PAYLOAD: begin
        bytes_left_next = left_dec;
        res.valid       = 1'b1;
        res.kind        = mlfd_pkg::KIND_DATA;
        res.data        = in_byte;
        if (left_dec == '0) begin
          res.last   = 1'b1;
          phase_next = mlfd_pkg::PH_MAGIC1;
        end
      end
      default: begin
        phase_next = mlfd_pkg::PH_MAGIC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mlfd_pkg::PH_MAGIC1;
      length_accum <= '0;
      bytes_left   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule
